@@ rtl/core/gcts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcts_pkg
// Shared types, constants and arithmetic helpers for the grid tangent stencil.
// ----------------------------------------------------------------------------
package gcts_pkg;

  localparam int COORD_BITS   = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int FACTOR_W     = 16;
  localparam int FRAC_BITS    = 14;
  localparam int PROD_W       = DIFF_W + FACTOR_W + 2;
  localparam int Q_W          = PROD_W - FRAC_BITS;
  localparam int TAN_W        = 20;
  localparam int COL_OUT_W    = 8;
  localparam int ROW_W        = 12;
  localparam int COLS_W       = 9;
  localparam int ROWS_W       = 13;
  localparam int MIN_DIM      = 4;
  localparam int MAX_ROWS     = 4096;
  localparam int DEF_MAX_COLS = 256;
  localparam int ROW_BANKS    = 3;
  localparam int BANK_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TENSION_FACTOR = 2'd2;

  localparam logic [COLS_W-1:0]   RST_GRID_COLS      = 9'd4;
  localparam logic [ROWS_W-1:0]   RST_GRID_ROWS      = 13'd4;
  localparam logic [FACTOR_W-1:0] RST_TENSION_FACTOR = 16'd8192;

  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << (TAN_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] SAT_LO = ~SAT_HI;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [TAN_W-1:0]      tan_t;

  typedef struct packed {
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
  } in_item_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] point_col;
    logic [ROW_W-1:0]     point_row;
    tan_t                 tan_u_x;
    tan_t                 tan_u_y;
    tan_t                 tan_u_z;
    tan_t                 tan_v_x;
    tan_t                 tan_v_y;
    tan_t                 tan_v_z;
    logic                 run_last;
  } out_item_t;

  typedef struct packed {
    tan_t u_x;
    tan_t u_y;
    tan_t u_z;
    tan_t v_x;
    tan_t v_y;
    tan_t v_z;
  } tangents_t;

  // which grid point a result belongs to, relative to the vertex at (c, r)
  typedef enum logic [2:0] {
    RES_PREV_ROW = 3'b001,  // (c, r-1)
    RES_PREV_COL = 3'b010,  // (c-1, r), last row only
    RES_LAST_COL = 3'b100   // (c, r), last row and last column only
  } res_kind_t;

  // neighborhood of the vertex held in the stencil register
  typedef struct packed {
    in_item_t cur;          // (c, r)
    in_item_t left1;        // (c-1, r)
    in_item_t left2;        // (c-2, r)
    in_item_t above;        // (c, r-1)
    in_item_t above_right;  // (c+1, r-1)
    in_item_t above_left;   // (c-1, r-1)
    in_item_t above2;       // (c, r-2)
  } window_t;

  typedef struct packed {
    res_kind_t kind;
    logic      first_col;
    logic      second_col;
    logic      last_col;
    logic      first_row;   // vertex on row 1, so the previous row is the top border
  } sel_t;

  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // factor * diff (doubled on a border), floor shift by 14, saturate
  function automatic tan_t tan_scale(input diff_t diff, input logic [FACTOR_W-1:0] factor,
                                     input logic twice);
    logic signed [FACTOR_W+1:0] f;
    logic signed [PROD_W-1:0]   prod;
    logic signed [Q_W-1:0]      q;
    f    = twice ? $signed({1'b0, factor, 1'b0}) : $signed({2'b00, factor});
    prod = PROD_W'(diff) * PROD_W'(f);
    q    = prod[PROD_W-1:FRAC_BITS];
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[TAN_W-1:0];
  endfunction

endpackage

@@ rtl/core/grid_catmull_tangent_stencil_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_catmull_tangent_stencil_core
// Catmull-Rom u/v tangents over a raster-ordered grid of 3D control points.
// ----------------------------------------------------------------------------
// Vertices enter in raster order, column fastest, and are taken one per cycle while in_stall is low.
// Each vertex is written into one of three row buffers (MAX_COLS entries
// each, two read ports per buffer) while the row above it is read at the
// same column and the next; the two vertices before it in its own row sit in
// registers. The tangents for a grid point pass through the stencil register
// and then the output register after the transfer of the vertex that completes
// its stencil, so results lag by one row. Rows 1 onward give one result per
// vertex. On the last row a vertex gives two results from column 1 on and
// three at the last column, given one at a time, so the input is held until
// the last of them is emitted; the output register is the only
// limit on rate. run_last marks the final result of a vertex. The row
// buffers are not cleared after reset and need no clearing pass. Any
// register write restarts the grid at row 0, column 0.
// ----------------------------------------------------------------------------
module grid_catmull_tangent_stencil_core #(
  parameter int MAX_COLS = gcts_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gcts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gcts_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gcts_pkg::out_item_t             out_data
);
  import gcts_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int NW = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;

  // configuration
  logic [COLS_W-1:0]   grid_cols;
  logic [ROWS_W-1:0]   grid_rows;
  logic [FACTOR_W-1:0] tension_factor;
  logic                cfg_hit;

  logic [NW-1:0]     cols_ext, ncols;
  logic [ROWS_W-1:0] nrows;
  logic [CW-1:0]     last_col;
  logic [ROW_W-1:0]  last_row;

  // position of the next vertex
  logic [CW-1:0]     col_count;
  logic [ROW_W-1:0]  row_count;
  logic [BANK_W-1:0] bank;
  logic [CW-1:0]     col_count_next;
  logic [ROW_W-1:0]  row_count_next;
  logic [BANK_W-1:0] bank_next;
  logic [CW-1:0]     col_ahead;

  // stencil register
  logic [CW-1:0]     s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [BANK_W-1:0] s1_bank;
  logic              s1_first_col, s1_second_col, s1_last_col, s1_first_row;
  logic [2:0]        pend, pend_new, pend_next, kind_oh;
  in_item_t          cur, left1, left2, above_left;

  logic [BANK_W-1:0] above_bank, above2_bank;
  in_item_t          rd_a [ROW_BANKS];
  in_item_t          rd_b [ROW_BANKS];

  logic       accept, out_free, emit, is_last_row;
  window_t    win;
  sel_t       sel;
  tangents_t  tang;
  out_item_t  res_item;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (cfg_index) inside
      REG_GRID_COLS, REG_GRID_ROWS, REG_TENSION_FACTOR: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols      <= RST_GRID_COLS;
      grid_rows      <= RST_GRID_ROWS;
      tension_factor <= RST_TENSION_FACTOR;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_COLS:      grid_cols      <= cfg_data[COLS_W-1:0];
        REG_GRID_ROWS:      grid_rows      <= cfg_data[ROWS_W-1:0];
        REG_TENSION_FACTOR: tension_factor <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp grid size to the supported range
  always_comb begin
    cols_ext = NW'(grid_cols);
    if (cols_ext < NW'(MIN_DIM)) begin
      ncols = NW'(MIN_DIM);
    end else if (cols_ext > NW'(MAX_COLS)) begin
      ncols = NW'(MAX_COLS);
    end else begin
      ncols = cols_ext;
    end
    if (grid_rows < ROWS_W'(MIN_DIM)) begin
      nrows = ROWS_W'(MIN_DIM);
    end else if (grid_rows > ROWS_W'(MAX_ROWS)) begin
      nrows = ROWS_W'(MAX_ROWS);
    end else begin
      nrows = grid_rows;
    end
  end

  assign last_col = CW'(ncols - NW'(1));
  assign last_row = ROW_W'(nrows - ROWS_W'(1));

  // --------------------------------------------------------------------------
  // handshake and result sequencing
  // --------------------------------------------------------------------------
  assign out_free  = !out_valid || !out_stall;
  assign emit      = out_free && (pend != 3'b000);
  assign kind_oh   = pend & (~pend + 3'd1);
  assign pend_next = pend & ~kind_oh;
  assign in_stall  = (pend != 3'b000) && !(emit && (pend_next == 3'b000));
  assign accept    = in_valid && !in_stall;

  assign is_last_row = (row_count == last_row);
  assign pend_new = {is_last_row && (col_count == last_col),
                     is_last_row && (col_count != '0),
                     row_count != '0};

  always_comb begin
    col_count_next = col_count + CW'(1);
    row_count_next = row_count;
    bank_next      = bank;
    if (col_count == last_col) begin
      col_count_next = '0;
      if (is_last_row) begin
        row_count_next = '0;
        bank_next      = '0;
      end else begin
        row_count_next = row_count + ROW_W'(1);
        bank_next      = (bank == BANK_W'(ROW_BANKS - 1)) ? '0 : bank + BANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      bank      <= '0;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_hit) begin
        col_count <= '0;
        row_count <= '0;
        bank      <= '0;
      end else if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
        bank      <= bank_next;
      end
      if (accept) begin
        pend <= pend_new;
      end else if (emit) begin
        pend <= pend_next;
      end
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  // --------------------------------------------------------------------------
  // row buffers: vertex written to its row's bank, every bank read
  // --------------------------------------------------------------------------
  assign col_ahead = (col_count == last_col) ? col_count : col_count + CW'(1);

  for (genvar g = 0; g < ROW_BANKS; g++) begin : g_bank
    gcts_row_ram #(
      .DEPTH (MAX_COLS)
    ) u_row_ram (
      .clk       (clk),
      .wr_en     (accept && (bank == BANK_W'(g))),
      .wr_addr   (col_count),
      .wr_data   (in_data),
      .rd_en     (accept),
      .rd_addr_a (col_count),
      .rd_addr_b (col_ahead),
      .rd_data_a (rd_a[g]),
      .rd_data_b (rd_b[g])
    );
  end

  assign above_bank  = (s1_bank == '0) ? BANK_W'(ROW_BANKS - 1) : s1_bank - BANK_W'(1);
  assign above2_bank = (s1_bank == BANK_W'(ROW_BANKS - 1)) ? '0 : s1_bank + BANK_W'(1);

  // stencil register; history shifts on every transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col        <= col_count;
      s1_row        <= row_count;
      s1_bank       <= bank;
      s1_first_col  <= (col_count == '0);
      s1_second_col <= (col_count == CW'(1));
      s1_last_col   <= (col_count == last_col);
      s1_first_row  <= (row_count == ROW_W'(1));
      cur           <= in_data;
      left1         <= cur;
      left2         <= left1;
      above_left    <= rd_a[above_bank];
    end
  end

  assign win.cur         = cur;
  assign win.left1       = left1;
  assign win.left2       = left2;
  assign win.above       = rd_a[above_bank];
  assign win.above_right = rd_b[above_bank];
  assign win.above_left  = above_left;
  assign win.above2      = rd_a[above2_bank];

  assign sel.kind       = res_kind_t'(kind_oh);
  assign sel.first_col  = s1_first_col;
  assign sel.second_col = s1_second_col;
  assign sel.last_col   = s1_last_col;
  assign sel.first_row  = s1_first_row;

  gcts_tangent u_tangent (
    .factor (tension_factor),
    .win    (win),
    .sel    (sel),
    .tang   (tang)
  );

  always_comb begin
    res_item.point_col = COL_OUT_W'(s1_col);
    res_item.point_row = s1_row;
    case (sel.kind)
      RES_PREV_ROW: res_item.point_row = s1_row - ROW_W'(1);
      RES_PREV_COL: res_item.point_col = COL_OUT_W'(s1_col - CW'(1));
      default: ;
    endcase
    res_item.tan_u_x  = tang.u_x;
    res_item.tan_u_y  = tang.u_y;
    res_item.tan_u_z  = tang.u_z;
    res_item.tan_v_x  = tang.v_x;
    res_item.tan_v_y  = tang.v_y;
    res_item.tan_v_z  = tang.v_z;
    res_item.run_last = (pend_next == 3'b000);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_col_in_grid: assert property (@(posedge clk) disable iff (rst)
    col_count <= last_col)
    else $error("column counter beyond the last column");

  a_row_in_grid: assert property (@(posedge clk) disable iff (rst)
    row_count <= last_row)
    else $error("row counter beyond the last row");

  a_bank_range: assert property (@(posedge clk) disable iff (rst)
    bank <= BANK_W'(ROW_BANKS - 1))
    else $error("row bank select out of range");

  a_left_needs_col: assert property (@(posedge clk) disable iff (rst)
    pend[1] |-> !s1_first_col)
    else $error("left result pending for a first-column vertex");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.run_last |=> out_valid)
    else $error("result sequence of a vertex broken off before run_last");
`endif

endmodule

@@ rtl/core/gcts_row_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcts_row_ram
// One row buffer: single write port, two registered read ports.
// ----------------------------------------------------------------------------
module gcts_row_ram #(
  parameter int DEPTH = gcts_pkg::DEF_MAX_COLS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  gcts_pkg::in_item_t wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr_a,
  input  logic [AW-1:0]      rd_addr_b,
  output gcts_pkg::in_item_t rd_data_a,
  output gcts_pkg::in_item_t rd_data_b
);
  import gcts_pkg::*;

  in_item_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ rtl/core/gcts_tangent.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcts_tangent
// Picks the stencil operands for one result and scales the six differences.
// ----------------------------------------------------------------------------
module gcts_tangent (
  input  logic [gcts_pkg::FACTOR_W-1:0] factor,
  input  gcts_pkg::window_t             win,
  input  gcts_pkg::sel_t                sel,
  output gcts_pkg::tangents_t           tang
);
  import gcts_pkg::*;

  in_item_t ua, ub, va, vb;
  logic     utw, vtw;

  always_comb begin
    ua  = win.cur;
    ub  = win.left1;
    utw = 1'b1;
    va  = win.cur;
    vb  = win.above;
    vtw = 1'b1;
    case (sel.kind)
      RES_PREV_ROW: begin
        if (sel.first_col) begin
          ua  = win.above_right;
          ub  = win.above;
          utw = 1'b1;
        end else if (sel.last_col) begin
          ua  = win.above;
          ub  = win.above_left;
          utw = 1'b1;
        end else begin
          ua  = win.above_right;
          ub  = win.above_left;
          utw = 1'b0;
        end
        if (sel.first_row) begin
          va  = win.cur;
          vb  = win.above;
          vtw = 1'b1;
        end else begin
          va  = win.cur;
          vb  = win.above2;
          vtw = 1'b0;
        end
      end
      RES_PREV_COL: begin
        // left neighbor of the current vertex, bottom border
        if (sel.second_col) begin
          ua  = win.cur;
          ub  = win.left1;
          utw = 1'b1;
        end else begin
          ua  = win.cur;
          ub  = win.left2;
          utw = 1'b0;
        end
        va  = win.left1;
        vb  = win.above_left;
        vtw = 1'b1;
      end
      default: begin
        // bottom right corner: both one-sided, already set above
      end
    endcase
  end

  assign tang.u_x = tan_scale(coord_diff(ua.coord_x, ub.coord_x), factor, utw);
  assign tang.u_y = tan_scale(coord_diff(ua.coord_y, ub.coord_y), factor, utw);
  assign tang.u_z = tan_scale(coord_diff(ua.coord_z, ub.coord_z), factor, utw);
  assign tang.v_x = tan_scale(coord_diff(va.coord_x, vb.coord_x), factor, vtw);
  assign tang.v_y = tan_scale(coord_diff(va.coord_y, vb.coord_y), factor, vtw);
  assign tang.v_z = tan_scale(coord_diff(va.coord_z, vb.coord_z), factor, vtw);

endmodule

@@ verif/grid_catmull_tangent_stencil_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_catmull_tangent_stencil_core_tb
// Self-checking bench for the grid tangent stencil. A scoreboard keeps its
// own row buffers and grid position, predicts every u/v tangent pair from
// the vertices actually transferred and checks the results in order. The
// grid shape and tension are changed between phases, and both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module grid_catmull_tangent_stencil_core_tb;
  import gcts_pkg::*;

  localparam int  GRID_COLS_CAP = 256;
  localparam int  SETTLE_CYCLES = 8;
  localparam int  WATCHDOG_LIMIT = 4000;
  localparam longint TAN_HI = 524287;
  localparam longint TAN_LO = -524288;

  class stencil_scoreboard;
    logic [COLS_W-1:0]   cols_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic [FACTOR_W-1:0] factor_reg;
    in_item_t            vertex_mem [3*GRID_COLS_CAP];
    int unsigned         col_pos;
    int unsigned         row_pos;
    out_item_t           tangents_due[$];
    int                  errors;

    function new();
      cols_reg   = RST_GRID_COLS;
      rows_reg   = RST_GRID_ROWS;
      factor_reg = RST_TENSION_FACTOR;
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
    endfunction

    // any register write starts a new grid
    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_GRID_COLS:      cols_reg   = value[COLS_W-1:0];
        REG_GRID_ROWS:      rows_reg   = value[ROWS_W-1:0];
        REG_TENSION_FACTOR: factor_reg = value[FACTOR_W-1:0];
        default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    function int pending();
      return tangents_due.size();
    endfunction

    function void add_due(out_item_t t);
      tangents_due = {tangents_due, t};
    endfunction

    function longint coord_of(in_item_t p, int k);
      case (k)
        0: return p.coord_x;
        1: return p.coord_y;
        default: return p.coord_z;
      endcase
    endfunction

    function in_item_t vertex_at(int unsigned row, int unsigned col);
      return vertex_mem[(row % 3) * GRID_COLS_CAP + (col % GRID_COLS_CAP)];
    endfunction

    function tan_t scale_tan(longint diff, bit twice);
      longint prod;
      longint q;
      prod = diff * longint'(factor_reg) * (twice ? 2 : 1);
      q = prod >>> FRAC_BITS;
      if (q > TAN_HI) q = TAN_HI;
      else if (q < TAN_LO) q = TAN_LO;
      return tan_t'(q);
    endfunction

    function out_item_t tangents_at(int unsigned c, int unsigned r, int unsigned ncols,
                                    int unsigned nrows, bit last);
      int unsigned ua_c, ub_c, va_r, vb_r;
      bit          u_twice, v_twice;
      tan_t        tu [3];
      tan_t        tv [3];
      out_item_t   o;
      // one-sided difference on the borders, central inside
      if (c == 0) begin
        ua_c = 1; ub_c = 0; u_twice = 1;
      end else if (c == ncols - 1) begin
        ua_c = c; ub_c = c - 1; u_twice = 1;
      end else begin
        ua_c = c + 1; ub_c = c - 1; u_twice = 0;
      end
      if (r == 0) begin
        va_r = 1; vb_r = 0; v_twice = 1;
      end else if (r == nrows - 1) begin
        va_r = r; vb_r = r - 1; v_twice = 1;
      end else begin
        va_r = r + 1; vb_r = r - 1; v_twice = 0;
      end
      for (int k = 0; k < 3; k++) begin
        tu[k] = scale_tan(coord_of(vertex_at(r, ua_c), k) - coord_of(vertex_at(r, ub_c), k),
                          u_twice);
        tv[k] = scale_tan(coord_of(vertex_at(va_r, c), k) - coord_of(vertex_at(vb_r, c), k),
                          v_twice);
      end
      o.point_col = c[COL_OUT_W-1:0];
      o.point_row = r[ROW_W-1:0];
      o.tan_u_x   = tu[0];
      o.tan_u_y   = tu[1];
      o.tan_u_z   = tu[2];
      o.tan_v_x   = tv[0];
      o.tan_v_y   = tv[1];
      o.tan_v_z   = tv[2];
      o.run_last  = last;
      return o;
    endfunction

    function void note_vertex(in_item_t v);
      int unsigned ncols, nrows, c, r;
      int          total, n;
      ncols = (cols_reg < MIN_DIM) ? MIN_DIM : (cols_reg > GRID_COLS_CAP) ? GRID_COLS_CAP
                                                                          : cols_reg;
      nrows = (rows_reg < MIN_DIM) ? MIN_DIM : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      c = (col_pos >= ncols) ? 0 : col_pos;
      r = (row_pos >= nrows) ? 0 : row_pos;
      vertex_mem[(r % 3) * GRID_COLS_CAP + c] = v;
      total = 0;
      if (r >= 1) total++;
      if (r == nrows - 1) begin
        if (c >= 1) total++;
        if (c == ncols - 1) total++;
      end
      n = 0;
      if (r >= 1) begin
        n++;
        add_due(tangents_at(c, r - 1, ncols, nrows, n == total));
      end
      // last row flushes its own points too
      if (r == nrows - 1) begin
        if (c >= 1) begin
          n++;
          add_due(tangents_at(c - 1, r, ncols, nrows, n == total));
        end
        if (c == ncols - 1) begin
          n++;
          add_due(tangents_at(c, r, ncols, nrows, n == total));
        end
      end
      c++;
      if (c >= ncols) begin
        c = 0;
        r++;
        if (r >= nrows) r = 0;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_field(string fname, longint got, longint want, int c, int r);
      if (got != want) begin
        report_mismatch($sformatf("point (%0d,%0d) %s got %0d want %0d",
                                  c, r, fname, got, want));
      end
    endtask

    task check_tangents(out_item_t got);
      out_item_t want;
      if (tangents_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result for point (%0d,%0d)",
                                  got.point_col, got.point_row));
        return;
      end
      want = tangents_due.pop_front();
      check_field("point_col", got.point_col, want.point_col, want.point_col, want.point_row);
      check_field("point_row", got.point_row, want.point_row, want.point_col, want.point_row);
      check_field("tan_u_x", got.tan_u_x, want.tan_u_x, want.point_col, want.point_row);
      check_field("tan_u_y", got.tan_u_y, want.tan_u_y, want.point_col, want.point_row);
      check_field("tan_u_z", got.tan_u_z, want.tan_u_z, want.point_col, want.point_row);
      check_field("tan_v_x", got.tan_v_x, want.tan_v_x, want.point_col, want.point_row);
      check_field("tan_v_y", got.tan_v_y, want.tan_v_y, want.point_col, want.point_row);
      check_field("tan_v_z", got.tan_v_z, want.tan_v_z, want.point_col, want.point_row);
      check_field("run_last", got.run_last, want.run_last, want.point_col, want.point_row);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_GRID_COLS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  stencil_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  grid_catmull_tangent_stencil_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // transfer monitor: inputs feed the prediction, outputs are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_vertex(in_data);
      if (out_valid && !out_stall) sb.check_tangents(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic coord_t pick_coord(bit extremes);
    if (extremes || $urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: return coord_t'(-32768);
        1: return coord_t'(32767);
        2: return coord_t'(0);
        default: return coord_t'(-1);
      endcase
    end
    return coord_t'($urandom);
  endfunction

  task automatic write_grid_regs(int cols, int rows, int factor);
    logic [CFG_DATA_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0]  regs [3];
    vals = '{CFG_DATA_W'(cols), CFG_DATA_W'(rows), CFG_DATA_W'(factor)};
    regs = '{REG_GRID_COLS, REG_GRID_ROWS, REG_TENSION_FACTOR};
    for (int i = 0; i < 3; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_vertex(in_item_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // sample on the falling edge so the monitor has seen the last rising edge
  task automatic wait_drained();
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // idle_mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both
  task automatic run_phase(bit do_cfg, int cols, int rows, int factor, int count,
                           int idle_mode, bit extremes, bit hold_mid);
    in_item_t v;
    send_idle_pct  = (idle_mode == 1) ? 83 : (idle_mode == 3) ? 28 : 0;
    recv_stall_pct = (idle_mode == 2) ? 83 : (idle_mode == 3) ? 28 : 0;
    if (do_cfg) write_grid_regs(cols, rows, factor);
    for (int i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      v.coord_x = pick_coord(extremes);
      v.coord_y = pick_coord(extremes);
      v.coord_z = pick_coord(extremes);
      send_vertex(v);
    end
    in_valid <= 1'b0;
    wait_drained();
    // row 0 vertices leave no result behind, give them time to retire
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset shape 4x4: one full grid of extreme coordinates, then wrap into the next
    run_phase(1'b0, 0, 0, 0, 20, 0, 1'b1, 1'b0);
    // under-range shape clamps to 4x4, largest tension
    run_phase(1'b1, 0, 0, 65535, 16, 1, 1'b1, 1'b0);
    run_phase(1'b1, 3, 3, 0, 16, 2, 1'b0, 1'b1);
    run_phase(1'b1, 5, 6, $urandom_range(65535), 30, 3, 1'b0, 1'b0);
    // over-range shape clamps to 256 columns and 4096 rows
    run_phase(1'b1, 511, 8191, $urandom_range(65535), 258, 3, 1'b0, 1'b0);
    repeat (16) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/gcts_pkg.sv
rtl/core/gcts_row_ram.sv
rtl/core/gcts_tangent.sv
rtl/core/grid_catmull_tangent_stencil_core.sv
verif/grid_catmull_tangent_stencil_core_tb.sv
